[src/sparse_set_component_store_core_defines.svh]
// ============================================================================
// Sparse-set component store - assertion macros
// Concurrent check macros for the assertions of the store core.
// ============================================================================
`ifndef SPARSE_SET_COMPONENT_STORE_CORE_DEFINES_SVH
`define SPARSE_SET_COMPONENT_STORE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSCS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sscs check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sscs check failed");
`else
`define SSCS_ASSERT_IMPLIES(label, ante, cons)
`define SSCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/sscs_pkg.sv]
// ============================================================================
// sscs_pkg
// Field widths, operation and status codes of the sparse-set component store.
// ============================================================================
package sscs_pkg;

    localparam int ENTITY_SPACE_DEF = 1024;
    localparam int CAPACITY_DEF     = 256;

    localparam int KIND_W   = 2;
    localparam int ENT_W    = 10;
    localparam int SLOT_W   = 8;
    localparam int PAY_W    = 64;
    localparam int STAT_W   = 3;
    localparam int LIVE_W   = 9;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [ENT_W-1:0]  entity_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [PAY_W-1:0]  payload_t;
    typedef logic [LIVE_W-1:0] live_t;

    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_LOOKUP = 2'd1;
    localparam kind_t KIND_REMOVE = 2'd2;
    localparam kind_t KIND_INDEX  = 2'd3;

    localparam status_t STAT_OK        = 3'd0;
    localparam status_t STAT_NOT_FOUND = 3'd1;
    localparam status_t STAT_FULL      = 3'd2;
    localparam status_t STAT_PRESENT   = 3'd3;
    localparam status_t STAT_RANGE     = 3'd4;

endpackage

[src/sscs_if.sv]
// ============================================================================
// sscs_req_if / sscs_rsp_if
// Valid/ready channels carrying store requests and their results.
// ============================================================================
interface sscs_req_if;
    import sscs_pkg::*;

    logic     valid;
    logic     ready;
    kind_t    kind;
    entity_t  entity_id;
    slot_t    slot_index;
    payload_t payload_in;

    modport source (output valid, kind, entity_id, slot_index, payload_in, input ready);
    modport sink   (input valid, kind, entity_id, slot_index, payload_in, output ready);
endinterface

interface sscs_rsp_if;
    import sscs_pkg::*;

    logic     valid;
    logic     ready;
    status_t  status;
    logic     found;
    payload_t payload_out;
    entity_t  owner_entity;
    live_t    live_count;

    modport source (output valid, status, found, payload_out, owner_entity, live_count,
                    input ready);
    modport sink   (input valid, status, found, payload_out, owner_entity, live_count,
                    output ready);
endinterface

[src/sscs_map.sv]
// ============================================================================
// sscs_map
// Sparse map: per-entity present bit and dense slot, registered reads.
// ============================================================================
module sscs_map #(
    parameter int DEPTH = sscs_pkg::ENTITY_SPACE_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int SW    = 8
) (
    input  logic          clk,
    input  logic [AW-1:0] raddr,
    output logic          rpresent,
    output logic [SW-1:0] rslot,
    input  logic          pres_we,
    input  logic [AW-1:0] pres_waddr,
    input  logic          pres_wdata,
    input  logic          slot_we,
    input  logic [AW-1:0] slot_waddr,
    input  logic [SW-1:0] slot_wdata
);
    logic          pres_mem [DEPTH];
    logic [SW-1:0] slot_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (pres_we)
        begin
            pres_mem[pres_waddr] <= pres_wdata;
        end
        rpresent <= pres_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        rslot <= slot_mem[raddr];
    end
endmodule

[src/sscs_dense.sv]
// ============================================================================
// sscs_dense
// Dense array: payload and owning entity per slot, registered read.
// ============================================================================
module sscs_dense #(
    parameter int DEPTH = sscs_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  sscs_pkg::payload_t wpayload,
    input  sscs_pkg::entity_t  wowner,
    input  logic [AW-1:0]      raddr,
    output sscs_pkg::payload_t rpayload,
    output sscs_pkg::entity_t  rowner
);
    import sscs_pkg::*;

    payload_t pay_mem [DEPTH];
    entity_t  own_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pay_mem[waddr] <= wpayload;
            own_mem[waddr] <= wowner;
        end
        rpayload <= pay_mem[raddr];
        rowner   <= own_mem[raddr];
    end
endmodule

[src/sparse_set_component_store_core.sv]
// ============================================================================
// sparse_set_component_store_core
// Sparse-set component store with swap-remove, run by a small sequencer.
// ============================================================================
// After reset the block sweeps the present bits clear, one entity a cycle, so
// it takes no request until all ENTITY_SPACE bits (1024 by default) are clear.
// After that a request is taken whenever the sequencer is idle, even while the
// last result still waits in the output register. Add, lookup miss, remove of
// the last entry, entity-at-index and every error go from the check state
// straight to finish; lookup hit and a remove that moves the last entry into
// the hole pass through a fetch state between, needed by the chain of registered
// reads: the sparse map first, then the dense array at the slot it gives. One
// shared comparator does the full, index range and hole-before-last checks.
`include "sparse_set_component_store_core_defines.svh"

module sparse_set_component_store_core #(
    parameter int ENTITY_SPACE = sscs_pkg::ENTITY_SPACE_DEF,
    parameter int CAPACITY     = sscs_pkg::CAPACITY_DEF
) (
    input logic       clk,
    input logic       rst_n,
    sscs_req_if.sink  req,
    sscs_rsp_if.source rsp
);
    import sscs_pkg::*;

    localparam int EW     = $clog2(ENTITY_SPACE);
    localparam int SW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CW > SLOT_W) ? CW : SLOT_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [EW-1:0] clr_addr_reg, clr_addr_next;
    logic [CW-1:0] count_reg, count_next;

    // latched request
    kind_t    kind_reg;
    entity_t  ent_reg;
    slot_t    sidx_reg;
    payload_t pay_reg;

    logic [SW-1:0] hole_reg, hole_next;

    // result being built
    status_t  res_status_reg, res_status_next;
    logic     res_found_reg, res_found_next;
    payload_t res_pay_reg, res_pay_next;
    entity_t  res_owner_reg, res_owner_next;

    // output register
    logic     out_valid_reg, out_valid_next;
    status_t  out_status_reg;
    logic     out_found_reg;
    payload_t out_pay_reg;
    entity_t  out_owner_reg;
    live_t    out_live_reg;

    // memory ports
    logic [EW-1:0] map_raddr;
    logic          map_rpresent;
    logic [SW-1:0] map_rslot;
    logic          pres_we, pres_wdata, slot_we;
    logic [EW-1:0] pres_waddr, slot_waddr;
    logic [SW-1:0] slot_wdata;

    logic          dense_we;
    logic [SW-1:0] dense_waddr, dense_raddr;
    payload_t      dense_wpay, dense_rpay;
    entity_t       dense_wown, dense_rown;

    // shared comparator
    logic [CMP_W-1:0] cmp_a, cmp_b;
    logic             cmp_lt;

    logic          ent_ok;
    logic [EW-1:0] ent_addr;
    logic [CW-1:0] last_cnt;
    logic          req_fire, out_load, add_ok;

    assign req_fire  = req.valid && req.ready;
    assign ent_ok    = (32'(ent_reg) < ENTITY_SPACE);
    assign ent_addr  = EW'(ent_reg);
    assign last_cnt  = CW'(count_reg - 1'b1);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.payload_out  = out_pay_reg;
    assign rsp.owner_entity = out_owner_reg;
    assign rsp.live_count   = out_live_reg;

    sscs_map #(
        .DEPTH (ENTITY_SPACE),
        .AW    (EW),
        .SW    (SW)
    ) u_map (
        .clk        (clk),
        .raddr      (map_raddr),
        .rpresent   (map_rpresent),
        .rslot      (map_rslot),
        .pres_we    (pres_we),
        .pres_waddr (pres_waddr),
        .pres_wdata (pres_wdata),
        .slot_we    (slot_we),
        .slot_waddr (slot_waddr),
        .slot_wdata (slot_wdata)
    );

    sscs_dense #(
        .DEPTH (CAPACITY),
        .AW    (SW)
    ) u_dense (
        .clk      (clk),
        .we       (dense_we),
        .waddr    (dense_waddr),
        .wpayload (dense_wpay),
        .wowner   (dense_wown),
        .raddr    (dense_raddr),
        .rpayload (dense_rpay),
        .rowner   (dense_rown)
    );

    // Comparator operand select: full check on add, index bound on slot
    // query, hole against last entry on remove.
    always_comb
    begin
        case (kind_reg)
            KIND_ADD:
            begin
                cmp_a = CMP_W'(count_reg);
                cmp_b = CMP_W'(CAPACITY);
            end
            KIND_INDEX:
            begin
                cmp_a = CMP_W'(sidx_reg);
                cmp_b = CMP_W'(count_reg);
            end
            default:
            begin
                cmp_a = CMP_W'(map_rslot);
                cmp_b = CMP_W'(last_cnt);
            end
        endcase
        cmp_lt = (cmp_a < cmp_b);
    end

    assign add_ok = (state_reg == S_CHECK) && (kind_reg == KIND_ADD) && ent_ok
                    && !map_rpresent && cmp_lt;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        count_next      = count_reg;
        hole_next       = hole_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_pay_next    = res_pay_reg;
        res_owner_next  = res_owner_reg;

        map_raddr   = ent_addr;
        dense_raddr = SW'(sidx_reg);

        pres_we     = 1'b0;
        pres_waddr  = ent_addr;
        pres_wdata  = 1'b0;
        slot_we     = 1'b0;
        slot_waddr  = ent_addr;
        slot_wdata  = SW'(count_reg);
        dense_we    = 1'b0;
        dense_waddr = SW'(count_reg);
        dense_wpay  = pay_reg;
        dense_wown  = ent_reg;

        case (state_reg)
            S_CLEAR:
            begin
                pres_we    = 1'b1;
                pres_waddr = clr_addr_reg;
                clr_addr_next = EW'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == EW'(ENTITY_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                map_raddr   = EW'(req.entity_id);
                dense_raddr = SW'(req.slot_index);
                if (req_fire)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                res_status_next = STAT_OK;
                res_found_next  = 1'b0;
                res_pay_next    = '0;
                res_owner_next  = '0;
                hole_next       = map_rslot;
                state_next      = S_FINISH;
                if (kind_reg == KIND_INDEX)
                begin
                    if (cmp_lt)
                    begin
                        res_owner_next = dense_rown;
                    end
                    else
                    begin
                        res_status_next = STAT_RANGE;
                    end
                end
                else if (!ent_ok)
                begin
                    res_status_next = STAT_RANGE;
                end
                else
                begin
                    case (kind_reg)
                        KIND_ADD:
                        begin
                            if (map_rpresent)
                            begin
                                res_status_next = STAT_PRESENT;
                            end
                            else if (!cmp_lt)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                dense_we   = 1'b1;
                                slot_we    = 1'b1;
                                pres_we    = 1'b1;
                                pres_wdata = 1'b1;
                                count_next = CW'(count_reg + 1'b1);
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            if (map_rpresent)
                            begin
                                dense_raddr = map_rslot;
                                state_next  = S_FETCH;
                            end
                            else
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            // remove
                            if (!map_rpresent || (count_reg == '0))
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                            else if (cmp_lt)
                            begin
                                // hole before the last entry: fetch the last one
                                dense_raddr = SW'(last_cnt);
                                state_next  = S_FETCH;
                            end
                            else
                            begin
                                pres_we    = 1'b1;
                                count_next = last_cnt;
                            end
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                state_next = S_FINISH;
                if (kind_reg == KIND_LOOKUP)
                begin
                    res_found_next = 1'b1;
                    res_pay_next   = dense_rpay;
                end
                else
                begin
                    // swap-remove: last entry into the hole, repoint its owner
                    dense_we    = 1'b1;
                    dense_waddr = hole_reg;
                    dense_wpay  = dense_rpay;
                    dense_wown  = dense_rown;
                    slot_we     = 1'b1;
                    slot_waddr  = EW'(dense_rown);
                    slot_wdata  = hole_reg;
                    pres_we     = 1'b1;
                    count_next  = last_cnt;
                end
            end

            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req.kind;
            ent_reg  <= req.entity_id;
            sidx_reg <= req.slot_index;
            pay_reg  <= req.payload_in;
        end
        hole_reg       <= hole_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_pay_reg    <= res_pay_next;
        res_owner_reg  <= res_owner_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_pay_reg    <= res_pay_reg;
            out_owner_reg  <= res_owner_reg;
            out_live_reg   <= LIVE_W'(count_reg);
        end
    end

    `SSCS_ASSERT_IMPLIES(a_count_cap, 1'b1, count_reg <= CW'(CAPACITY))
    `SSCS_ASSERT_NEXT(a_req_to_check, req_fire, state_reg == S_CHECK)
    `SSCS_ASSERT_NEXT(a_add_grows, add_ok, count_reg == CW'($past(count_reg) + 1'b1))
    `SSCS_ASSERT_IMPLIES(a_found_ok, rsp.valid && rsp.found, rsp.status == STAT_OK)

endmodule
